[rtl/mvwm_pkg.sv]
// ============================================================================
// mvwm_pkg: shared types, constants and tables of the wavetable mixer
// Holds the field widths, the sine table, the reciprocal table and the
// control bundles that pass between the sequencer, the lanes and the merge.
// ============================================================================
package mvwm_pkg;

    // Field widths of the stream beats.
    localparam int COUNT_W     = 4;
    localparam int FREQ_W      = 19;
    localparam int SCALE_W     = 32;
    localparam int SAMPLE_W    = 12;
    localparam int NUM_VOICES  = 8;
    localparam int MAX_VOICES  = 8;
    localparam int S_TDATA_W   = 160;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Phase format: unsigned Q8.16 over a 256-entry table.
    localparam int TABLE_SIZE      = 256;
    localparam int IDX_W           = $clog2(TABLE_SIZE);
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_W         = IDX_W + PHASE_FRAC_BITS;
    localparam int SCALE_SHIFT     = 20;
    localparam int PROD_W          = FREQ_W + SCALE_W;

    // Division by the voice count is a multiply by a rounded-up reciprocal.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int DIVP_W      = SAMPLE_W + RECIP_W;

    // Width of a partial sum in the merge stage.
    localparam int SUM_W = SAMPLE_W + $clog2(NUM_VOICES);

    // Configuration registers.
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SCALE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_VALUE  = 8'd1;
    localparam logic [SCALE_W-1:0]     STEP_SCALE_RESET = 32'd16621490;
    localparam logic [SAMPLE_W-1:0]    OFF_VALUE_RESET  = 12'h000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PHASE,
        ST_DIV,
        ST_SUM_A,
        ST_SUM_B,
        ST_HOLD
    } seq_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
        logic div;
    } lane_ctrl_t;

    typedef struct packed {
        logic sum_a;
        logic sum_b;
    } merge_ctrl_t;

    typedef logic [NUM_VOICES-1:0][SAMPLE_W-1:0] quot_vec_t;

    localparam logic [SAMPLE_W-1:0] SINE_ROM [0:TABLE_SIZE-1] = '{
        12'h800, 12'h832, 12'h864, 12'h896, 12'h8c8, 12'h8fa, 12'h92c, 12'h95e,
        12'h98f, 12'h9c0, 12'h9f1, 12'ha22, 12'ha52, 12'ha82, 12'hab1, 12'hae0,
        12'hb0f, 12'hb3d, 12'hb6b, 12'hb98, 12'hbc5, 12'hbf1, 12'hc1c, 12'hc47,
        12'hc71, 12'hc9a, 12'hcc3, 12'hceb, 12'hd12, 12'hd39, 12'hd5f, 12'hd83,
        12'hda7, 12'hdca, 12'hded, 12'he0e, 12'he2e, 12'he4e, 12'he6c, 12'he8a,
        12'hea6, 12'hec1, 12'hedc, 12'hef5, 12'hf0d, 12'hf24, 12'hf3a, 12'hf4f,
        12'hf63, 12'hf76, 12'hf87, 12'hf98, 12'hfa7, 12'hfb5, 12'hfc2, 12'hfcd,
        12'hfd8, 12'hfe1, 12'hfe9, 12'hff0, 12'hff5, 12'hff9, 12'hffd, 12'hffe,
        12'hfff, 12'hffe, 12'hffd, 12'hff9, 12'hff5, 12'hff0, 12'hfe9, 12'hfe1,
        12'hfd8, 12'hfcd, 12'hfc2, 12'hfb5, 12'hfa7, 12'hf98, 12'hf87, 12'hf76,
        12'hf63, 12'hf4f, 12'hf3a, 12'hf24, 12'hf0d, 12'hef5, 12'hedc, 12'hec1,
        12'hea6, 12'he8a, 12'he6c, 12'he4e, 12'he2e, 12'he0e, 12'hded, 12'hdca,
        12'hda7, 12'hd83, 12'hd5f, 12'hd39, 12'hd12, 12'hceb, 12'hcc3, 12'hc9a,
        12'hc71, 12'hc47, 12'hc1c, 12'hbf1, 12'hbc5, 12'hb98, 12'hb6b, 12'hb3d,
        12'hb0f, 12'hae0, 12'hab1, 12'ha82, 12'ha52, 12'ha22, 12'h9f1, 12'h9c0,
        12'h98f, 12'h95e, 12'h92c, 12'h8fa, 12'h8c8, 12'h896, 12'h864, 12'h832,
        12'h800, 12'h7cd, 12'h79b, 12'h769, 12'h737, 12'h705, 12'h6d3, 12'h6a1,
        12'h670, 12'h63f, 12'h60e, 12'h5dd, 12'h5ad, 12'h57d, 12'h54e, 12'h51f,
        12'h4f0, 12'h4c2, 12'h494, 12'h467, 12'h43a, 12'h40e, 12'h3e3, 12'h3b8,
        12'h38e, 12'h365, 12'h33c, 12'h314, 12'h2ed, 12'h2c6, 12'h2a0, 12'h27c,
        12'h258, 12'h235, 12'h212, 12'h1f1, 12'h1d1, 12'h1b1, 12'h193, 12'h175,
        12'h159, 12'h13e, 12'h123, 12'h10a, 12'h0f2, 12'h0db, 12'h0c5, 12'h0b0,
        12'h09c, 12'h089, 12'h078, 12'h067, 12'h058, 12'h04a, 12'h03d, 12'h032,
        12'h027, 12'h01e, 12'h016, 12'h00f, 12'h00a, 12'h006, 12'h002, 12'h001,
        12'h000, 12'h001, 12'h002, 12'h006, 12'h00a, 12'h00f, 12'h016, 12'h01e,
        12'h027, 12'h032, 12'h03d, 12'h04a, 12'h058, 12'h067, 12'h078, 12'h089,
        12'h09c, 12'h0b0, 12'h0c5, 12'h0db, 12'h0f2, 12'h10a, 12'h123, 12'h13e,
        12'h159, 12'h175, 12'h193, 12'h1b1, 12'h1d1, 12'h1f1, 12'h212, 12'h235,
        12'h258, 12'h27c, 12'h2a0, 12'h2c6, 12'h2ed, 12'h314, 12'h33c, 12'h365,
        12'h38e, 12'h3b8, 12'h3e3, 12'h40e, 12'h43a, 12'h467, 12'h494, 12'h4c2,
        12'h4f0, 12'h51f, 12'h54e, 12'h57d, 12'h5ad, 12'h5dd, 12'h60e, 12'h63f,
        12'h670, 12'h6a1, 12'h6d3, 12'h705, 12'h737, 12'h769, 12'h79b, 12'h7cd
    };

    // ceil(2^16 / count). With a 12-bit dividend the truncated product is
    // exact for every count from one to eight.
    function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/mvwm_lane.sv]
// ============================================================================
// mvwm_lane: one voice of the mixer
// Multiplies the frequency by the step scale, advances and wraps the phase,
// reads the sine table and divides the entry by the active voice count.
// ============================================================================
module mvwm_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mvwm_pkg::lane_ctrl_t           ctrl,
    input  logic                           active,
    input  logic [mvwm_pkg::FREQ_W-1:0]    freq,
    input  logic [mvwm_pkg::SCALE_W-1:0]   step_scale,
    input  logic [mvwm_pkg::RECIP_W-1:0]   recip,
    output logic [mvwm_pkg::SAMPLE_W-1:0]  quot
);

    logic                             active_reg;
    logic [mvwm_pkg::FREQ_W-1:0]      freq_reg;
    logic [mvwm_pkg::PHASE_W-1:0]     inc_reg;
    logic [mvwm_pkg::PHASE_W-1:0]     phase_reg;
    logic [mvwm_pkg::PHASE_W-1:0]     phase_next;
    logic [mvwm_pkg::SAMPLE_W-1:0]    entry_reg;
    logic [mvwm_pkg::SAMPLE_W-1:0]    quot_reg;
    logic [mvwm_pkg::PROD_W-1:0]      prod;
    logic [mvwm_pkg::DIVP_W-1:0]      divp;

    assign prod       = mvwm_pkg::PROD_W'(freq_reg) * mvwm_pkg::PROD_W'(step_scale);
    // The add wraps at the phase width, which is the table length in phase units.
    assign phase_next = phase_reg + inc_reg;
    assign divp       = mvwm_pkg::DIVP_W'(entry_reg) * mvwm_pkg::DIVP_W'(recip);
    assign quot       = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                active_reg <= active;
            end
            if (ctrl.upd && active_reg)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            freq_reg <= freq;
        end
        if (ctrl.mul)
        begin
            inc_reg <= prod[mvwm_pkg::SCALE_SHIFT +: mvwm_pkg::PHASE_W];
        end
        if (ctrl.upd)
        begin
            entry_reg <= mvwm_pkg::SINE_ROM[phase_next[mvwm_pkg::PHASE_W-1 -: mvwm_pkg::IDX_W]];
        end
        if (ctrl.div)
        begin
            quot_reg <= active_reg ? divp[mvwm_pkg::RECIP_SHIFT +: mvwm_pkg::SAMPLE_W] : '0;
        end
    end

`ifndef SYNTHESIS
    // A voice that is not active this tick keeps its phase.
    a_idle_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.upd && !active_reg) |=> $stable(phase_reg))
        else $error("inactive voice phase changed");
`endif

endmodule

[rtl/mvwm_merge.sv]
// ============================================================================
// mvwm_merge: sums the voice quotients into one sample
// Two registered levels: two half sums, then the final sum or the off value.
// ============================================================================
module mvwm_merge (
    input  logic                           clk,
    input  mvwm_pkg::merge_ctrl_t          ctrl,
    input  mvwm_pkg::quot_vec_t            quots,
    input  logic                           no_voice,
    input  logic [mvwm_pkg::SAMPLE_W-1:0]  off_value,
    output logic [mvwm_pkg::SAMPLE_W-1:0]  sample
);

    localparam int HALF = mvwm_pkg::NUM_VOICES / 2;

    logic [mvwm_pkg::SUM_W-1:0]    lo_sum;
    logic [mvwm_pkg::SUM_W-1:0]    hi_sum;
    logic [mvwm_pkg::SUM_W-1:0]    lo_reg;
    logic [mvwm_pkg::SUM_W-1:0]    hi_reg;
    logic [mvwm_pkg::SUM_W-1:0]    total;
    logic [mvwm_pkg::SAMPLE_W-1:0] sample_reg;

    always_comb
    begin
        lo_sum = '0;
        hi_sum = '0;
        for (int v = 0; v < mvwm_pkg::NUM_VOICES; v++)
        begin
            if (v < HALF)
                lo_sum = lo_sum + mvwm_pkg::SUM_W'(quots[v]);
            else
                hi_sum = hi_sum + mvwm_pkg::SUM_W'(quots[v]);
        end
    end

    assign total  = lo_reg + hi_reg;
    assign sample = sample_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_a)
        begin
            lo_reg <= lo_sum;
            hi_reg <= hi_sum;
        end
        if (ctrl.sum_b)
        begin
            sample_reg <= no_voice ? off_value : total[mvwm_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

[rtl/multi_voice_wavetable_mixer.sv]
// ============================================================================
// multi_voice_wavetable_mixer: eight-voice sine wavetable oscillator and mixer
// Each input beat is one sample tick. Every active voice advances its phase,
// reads the sine table and contributes its entry divided by the voice count;
// the contributions are summed into one 12-bit sample per beat.
// ============================================================================
//
//  Channel   Direction  Beat contents
//  s_*       in         tdata: voice_count[3:0], freq_voice_0..7 (19 bits each)
//  m_*       out        tdata: sample[11:0]
//  cfg_*     in         cfg_index selects step_scale (0) or off_value (1)
//
// A beat is accepted at a clock edge where s_tvalid and s_tready are high.
// The sequencer then walks the eight lanes through multiply, phase update
// with table read, reciprocal divide and two summing levels: the sample then
// moves into the output register, and s_tready returns in that same cycle, so
// no new beat is taken until the last one is through the sequencer. A stalled
// sink holds the sequencer in its last step, and a new beat may be accepted
// while a finished sample waits.
// Reset (rst_n low, asynchronous) zeroes all voice phases and loads the
// default step scale and an off value of zero.
//
module multi_voice_wavetable_mixer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input beat: [3:0] voice_count, then freq_voice_0 at [22:4] up to
    // freq_voice_7 at [155:137], zero padding above.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mvwm_pkg::S_TDATA_W-1:0]       s_tdata,
    // Output beat: [11:0] sample, zero padding above.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mvwm_pkg::M_TDATA_W-1:0]       m_tdata,
    // Configuration writes.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mvwm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mvwm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mvwm_pkg::seq_state_t               state_reg;
    mvwm_pkg::seq_state_t               state_next;
    mvwm_pkg::lane_ctrl_t               lane_ctrl;
    mvwm_pkg::merge_ctrl_t              merge_ctrl;
    mvwm_pkg::quot_vec_t                quots;

    logic [mvwm_pkg::SCALE_W-1:0]       step_scale_reg;
    logic [mvwm_pkg::SAMPLE_W-1:0]      off_value_reg;
    logic [mvwm_pkg::COUNT_W-1:0]       count_reg;
    logic [mvwm_pkg::COUNT_W-1:0]       count_sat;
    logic                               m_tvalid_reg;
    logic [mvwm_pkg::SAMPLE_W-1:0]      sample_out_reg;
    logic [mvwm_pkg::SAMPLE_W-1:0]      merged_sample;
    logic [mvwm_pkg::RECIP_W-1:0]       recip_val;
    logic                               s_accept;
    logic                               out_load;

    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(mvwm_pkg::M_TDATA_W - mvwm_pkg::SAMPLE_W){1'b0}}, sample_out_reg};

    // The voice count is clipped to the number of voices the block has.
    assign count_sat = (s_tdata[mvwm_pkg::COUNT_W-1:0] > mvwm_pkg::COUNT_W'(mvwm_pkg::MAX_VOICES))
                       ? mvwm_pkg::COUNT_W'(mvwm_pkg::MAX_VOICES)
                       : s_tdata[mvwm_pkg::COUNT_W-1:0];
    assign recip_val = mvwm_pkg::recip(count_reg);

    // Sequencer: one step of the lane and merge pipeline per state.
    always_comb
    begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        out_load         = 1'b0;
        lane_ctrl        = '0;
        merge_ctrl       = '0;
        case (state_reg)
            mvwm_pkg::ST_IDLE:
            begin
                s_tready       = 1'b1;
                lane_ctrl.load = s_tvalid;
                if (s_tvalid)
                    state_next = mvwm_pkg::ST_MUL;
            end
            mvwm_pkg::ST_MUL:
            begin
                lane_ctrl.mul = 1'b1;
                state_next    = mvwm_pkg::ST_PHASE;
            end
            mvwm_pkg::ST_PHASE:
            begin
                lane_ctrl.upd = 1'b1;
                state_next    = mvwm_pkg::ST_DIV;
            end
            mvwm_pkg::ST_DIV:
            begin
                lane_ctrl.div = 1'b1;
                state_next    = mvwm_pkg::ST_SUM_A;
            end
            mvwm_pkg::ST_SUM_A:
            begin
                merge_ctrl.sum_a = 1'b1;
                state_next       = mvwm_pkg::ST_SUM_B;
            end
            mvwm_pkg::ST_SUM_B:
            begin
                merge_ctrl.sum_b = 1'b1;
                state_next       = mvwm_pkg::ST_HOLD;
            end
            mvwm_pkg::ST_HOLD:
            begin
                // Move the sample out once the output register is free.
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = mvwm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mvwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mvwm_pkg::ST_IDLE;
            step_scale_reg <= mvwm_pkg::STEP_SCALE_RESET;
            off_value_reg  <= mvwm_pkg::OFF_VALUE_RESET;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mvwm_pkg::REG_STEP_SCALE)
                    step_scale_reg <= cfg_data;
                else if (cfg_index == mvwm_pkg::REG_OFF_VALUE)
                    off_value_reg <= cfg_data[mvwm_pkg::SAMPLE_W-1:0];
            end
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            count_reg <= count_sat;
        if (out_load)
            sample_out_reg <= merged_sample;
    end

    // One lane per voice; lane v is active when v is below the voice count.
    for (genvar v = 0; v < mvwm_pkg::NUM_VOICES; v++)
    begin : g_lane
        mvwm_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lane_ctrl),
            .active     (mvwm_pkg::COUNT_W'(v) < count_sat),
            .freq       (s_tdata[mvwm_pkg::COUNT_W + v*mvwm_pkg::FREQ_W +: mvwm_pkg::FREQ_W]),
            .step_scale (step_scale_reg),
            .recip      (recip_val),
            .quot       (quots[v])
        );
    end

    mvwm_merge u_merge (
        .clk       (clk),
        .ctrl      (merge_ctrl),
        .quots     (quots),
        .no_voice  (count_reg == '0),
        .off_value (off_value_reg),
        .sample    (merged_sample)
    );

`ifndef SYNTHESIS
    // After a beat is taken no second beat enters until the sample is out.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("input accepted while a tick is in flight");

    // A finished sample never overwrites one that the sink has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output sample overwritten");

    // A tick without active voices gives the off value.
    a_off_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (count_reg == '0)) |=>
            (m_tdata[mvwm_pkg::SAMPLE_W-1:0] == off_value_reg))
        else $error("silent tick did not give the off value");
`endif

endmodule
